[hdl/bcld_pkg.sv]
// Package: types, codes and the character glyph table of the combination lock display.
package bcld_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int ENTRY_LEN = 4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  localparam logic [7:0] OP_SHIFT  = 8'h01;
  localparam logic [7:0] OP_CLEAR  = 8'h02;
  localparam logic [7:0] OP_LOCK   = 8'h03;
  localparam logic [7:0] OP_UNLOCK = 8'h04;
  localparam logic [7:0] DASH_CHAR = 8'h2D;

  typedef logic [ENTRY_LEN-1:0][7:0] entry_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] segments_n;
    logic [3:0] digit_enable;
    logic       led_red;
    logic       led_green;
  } out_t;

  localparam logic [6:0] GLYPHS [41] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
    7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h0E,
    7'h76, 7'h38, 7'h00, 7'h54, 7'h3F, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
    7'h3E, 7'h3E, 7'h00, 7'h76, 7'h6E, 7'h5B,
    7'h00, 7'h40, 7'h00, 7'h63, 7'h08
  };

  localparam int GLYPH_SPACE = 36;
  localparam int GLYPH_DASH  = 37;
  localparam int GLYPH_STAR  = 39;
  localparam int GLYPH_UNDER = 40;

  function automatic logic [6:0] glyph_of(input logic [7:0] c);
    logic [6:0] g;
    g = 7'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      g = GLYPHS[6'(c - 8'h30)];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      g = GLYPHS[6'(c - 8'h41) + 6'd10];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      g = GLYPHS[6'(c - 8'h61) + 6'd10];
    end else if (c == 8'h20) begin
      g = GLYPHS[GLYPH_SPACE];
    end else if (c == 8'h2D) begin
      g = GLYPHS[GLYPH_DASH];
    end else if (c == 8'h2A) begin
      g = GLYPHS[GLYPH_STAR];
    end else if (c == 8'h5F) begin
      g = GLYPHS[GLYPH_UNDER];
    end
    return g;
  endfunction

endpackage

[hdl/bcld_disp.sv]
// Display scan: glyph decode of the current entry character and next scan position.
module bcld_disp import bcld_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
  parameter int SCAN_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  logic [SCAN_W-1:0] scan,
  input  entry_t            entry,
  output logic [6:0]        seg_n,
  output logic [3:0]        dig,
  output logic [SCAN_W-1:0] scan_nxt
);

  logic [1:0] pos;

  always_comb begin
    pos = 2'(scan);
    if (32'(scan) < ENTRY_LEN) begin
      seg_n = ~glyph_of(entry[pos]);
      dig   = 4'b0001 << pos;
    end else begin
      seg_n = 7'h7F;
      dig   = 4'b0000;
    end
    if (scan == SCAN_W'(DIGIT_COUNT - 1)) begin
      scan_nxt = '0;
    end else begin
      scan_nxt = scan + SCAN_W'(1);
    end
  end

endmodule

[hdl/bus_combination_lock_display_top.sv]
// Top level: bus-attached combination lock with multiplexed seven-segment display.
//
// Usage:
//   in_ channel carries one bus event per transaction: transaction start, byte
//   written, status read or display refresh tick. Each accepted transaction
//   yields exactly one out_ transaction with the read byte, the held segment
//   and digit drive, and the two indicator LEDs after the event.
//   The result is registered in out_r, or in skid_r while out_stall holds out_r.
//   Throughput: one transaction per cycle while in_stall is low; the update is
//   a single compare, shift and glyph decode between state and result registers.
//   A skid register behind the output register lets one more transaction in
//   while out_stall is high; in_stall rises only when both are full.
//   Reset (rst_n low, synchronous) unlocks, fills the entry with dashes,
//   blanks the segments, disables all digits and empties the output side.
//   The stored code is undefined until the first lock command writes it.
//   DIGIT_COUNT sets how many scan positions the refresh tick cycles through;
//   positions four and above show blank with no digit enabled.
module bus_combination_lock_display_top import bcld_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int SCAN_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [1:0]        bpos_r, bpos_nxt;
  logic [7:0]        opc_r, opc_nxt;
  entry_t            entry_r, entry_nxt;
  entry_t            code_r, code_nxt;
  logic              locked_r, locked_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt, scan_tick;
  logic [6:0]        seg_r, seg_nxt, seg_tick;
  logic [3:0]        dig_r, dig_nxt, dig_tick;

  out_t out_r, skid_r, res;
  logic out_v_r, skid_v_r;
  logic acc, match, done;

  bcld_disp #(.DIGIT_COUNT(DIGIT_COUNT), .SCAN_W(SCAN_W)) u_disp (
    .scan     (scan_r),
    .entry    (entry_r),
    .seg_n    (seg_tick),
    .dig      (dig_tick),
    .scan_nxt (scan_tick)
  );

  assign in_stall = skid_v_r;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    match = 1'b1;
    done  = 1'b0;
    for (int i = 0; i < ENTRY_LEN; i++) begin
      if (!done) begin
        if (entry_r[i] != code_r[i]) begin
          match = 1'b0;
          done  = 1'b1;
        end else if (entry_r[i] == 8'h00) begin
          done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    bpos_nxt   = bpos_r;
    opc_nxt    = opc_r;
    entry_nxt  = entry_r;
    code_nxt   = code_r;
    locked_nxt = locked_r;
    scan_nxt   = scan_r;
    seg_nxt    = seg_r;
    dig_nxt    = dig_r;
    res        = '0;
    unique case (cmd_t'(in_data.command))
      CMD_START: begin
        bpos_nxt = 2'd0;
        opc_nxt  = 8'h00;
      end
      CMD_WRITE: begin
        if (bpos_r == 2'd0) begin
          opc_nxt  = in_data.data_byte;
          bpos_nxt = 2'd1;
          if (in_data.data_byte == OP_CLEAR) begin
            entry_nxt = {ENTRY_LEN{DASH_CHAR}};
          end else if (in_data.data_byte == OP_LOCK) begin
            if (!locked_r) begin
              code_nxt   = entry_r;
              locked_nxt = 1'b1;
            end
          end else if (in_data.data_byte == OP_UNLOCK) begin
            if (locked_r && match) begin
              locked_nxt = 1'b0;
            end
          end
        end else if (bpos_r == 2'd1) begin
          bpos_nxt = 2'd2;
          if (opc_r == OP_SHIFT) begin
            for (int i = 0; i < ENTRY_LEN - 1; i++) begin
              entry_nxt[i] = entry_r[i+1];
            end
            entry_nxt[ENTRY_LEN-1] = in_data.data_byte;
          end
        end
      end
      CMD_READ: begin
        res.read_data = {7'd0, locked_r};
      end
      CMD_TICK: begin
        seg_nxt  = seg_tick;
        dig_nxt  = dig_tick;
        scan_nxt = scan_tick;
      end
      default: begin
      end
    endcase
    res.segments_n   = seg_nxt;
    res.digit_enable = dig_nxt;
    res.led_red      = !locked_nxt;
    res.led_green    = locked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r   <= 2'd0;
      opc_r    <= 8'h00;
      entry_r  <= {ENTRY_LEN{DASH_CHAR}};
      locked_r <= 1'b0;
      scan_r   <= '0;
      seg_r    <= 7'h7F;
      dig_r    <= 4'b0000;
    end else if (acc) begin
      bpos_r   <= bpos_nxt;
      opc_r    <= opc_nxt;
      entry_r  <= entry_nxt;
      locked_r <= locked_nxt;
      scan_r   <= scan_nxt;
      seg_r    <= seg_nxt;
      dig_r    <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      code_r <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || acc;
      skid_v_r <= 1'b0;
    end else if (acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
